### hw/rtl/sc2a_pkg.sv
// Shared types, constants and lookup functions for the scancode-to-ASCII FIFO.
package sc2a_pkg;

    // Item commands
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Set-1 scancodes with special handling
    localparam logic [7:0] SC_PREFIX  = 8'hE0;
    localparam logic [6:0] SC_LSHIFT  = 7'h2A;
    localparam logic [6:0] SC_RSHIFT  = 7'h36;
    localparam logic [6:0] SC_CTRL    = 7'h1D;
    localparam logic [6:0] SC_ALT     = 7'h38;
    localparam logic [6:0] SC_BKSP    = 7'h0E;
    localparam logic [6:0] SC_ENTER   = 7'h1C;

    // Extended make codes (after the prefix)
    localparam logic [7:0] SC_EXT_UP    = 8'h48;
    localparam logic [7:0] SC_EXT_DOWN  = 8'h50;
    localparam logic [7:0] SC_EXT_LEFT  = 8'h4B;
    localparam logic [7:0] SC_EXT_RIGHT = 8'h4D;
    localparam logic [7:0] SC_EXT_PGUP  = 8'h49;
    localparam logic [7:0] SC_EXT_PGDN  = 8'h51;

    localparam logic [7:0] CH_BKSP   = 8'h08;
    localparam logic [7:0] CH_ENTER  = 8'h0A;
    localparam logic [7:0] CH_CTRL_C = 8'h03;
    localparam logic [7:0] CH_LOW_C  = 8'h63;
    localparam logic [7:0] CH_UP_C   = 8'h43;

    // Number of extended key codes held in configuration
    localparam int NUM_EXT = 6;
    localparam int EXT_UP    = 0;
    localparam int EXT_DOWN  = 1;
    localparam int EXT_LEFT  = 2;
    localparam int EXT_RIGHT = 3;
    localparam int EXT_PGUP  = 4;
    localparam int EXT_PGDN  = 5;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_DECODE_ENABLE = 3'd0;
    localparam logic [2:0] REG_ARROW_UP      = 3'd1;
    localparam logic [2:0] REG_ARROW_DOWN    = 3'd2;
    localparam logic [2:0] REG_ARROW_LEFT    = 3'd3;
    localparam logic [2:0] REG_ARROW_RIGHT   = 3'd4;
    localparam logic [2:0] REG_PAGE_UP       = 3'd5;
    localparam logic [2:0] REG_PAGE_DOWN     = 3'd6;

    // Result queue in the back part
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUT,
        OP_POP
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] ch;
    } op_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] level;
    } result_t;

    typedef struct packed {
        logic [OQ_CW-1:0] oq_count;
        logic             stage_valid;
        logic             store_full;
        logic             store_empty;
    } back_status_t;

    // US-layout base table; codes 0x50 and above map to zero
    function automatic logic [7:0] ascii_lookup(input logic [6:0] mk);
        logic [7:0] c;
        case (mk)
            7'h01: c = 8'h1B;
            7'h02: c = 8'h31;
            7'h03: c = 8'h32;
            7'h04: c = 8'h33;
            7'h05: c = 8'h34;
            7'h06: c = 8'h35;
            7'h07: c = 8'h36;
            7'h08: c = 8'h37;
            7'h09: c = 8'h38;
            7'h0A: c = 8'h39;
            7'h0B: c = 8'h30;
            7'h0C: c = 8'h2D;
            7'h0D: c = 8'h3D;
            7'h0E: c = 8'h08;
            7'h0F: c = 8'h09;
            7'h10: c = 8'h71;
            7'h11: c = 8'h77;
            7'h12: c = 8'h65;
            7'h13: c = 8'h72;
            7'h14: c = 8'h74;
            7'h15: c = 8'h79;
            7'h16: c = 8'h75;
            7'h17: c = 8'h69;
            7'h18: c = 8'h6F;
            7'h19: c = 8'h70;
            7'h1A: c = 8'h5B;
            7'h1B: c = 8'h5D;
            7'h1C: c = 8'h0A;
            7'h1E: c = 8'h61;
            7'h1F: c = 8'h73;
            7'h20: c = 8'h64;
            7'h21: c = 8'h66;
            7'h22: c = 8'h67;
            7'h23: c = 8'h68;
            7'h24: c = 8'h6A;
            7'h25: c = 8'h6B;
            7'h26: c = 8'h6C;
            7'h27: c = 8'h3B;
            7'h28: c = 8'h27;
            7'h29: c = 8'h60;
            7'h2B: c = 8'h5C;
            7'h2C: c = 8'h7A;
            7'h2D: c = 8'h78;
            7'h2E: c = 8'h63;
            7'h2F: c = 8'h76;
            7'h30: c = 8'h62;
            7'h31: c = 8'h6E;
            7'h32: c = 8'h6D;
            7'h33: c = 8'h2C;
            7'h34: c = 8'h2E;
            7'h35: c = 8'h2F;
            7'h37: c = 8'h2A;
            7'h39: c = 8'h20;
            7'h4A: c = 8'h2D;
            7'h4E: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Shifted form of a base character
    function automatic logic [7:0] shift_map(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'h5C: c = 8'h7C;
            8'h31: c = 8'h21;
            8'h32: c = 8'h40;
            8'h33: c = 8'h23;
            8'h34: c = 8'h24;
            8'h35: c = 8'h25;
            8'h36: c = 8'h5E;
            8'h37: c = 8'h26;
            8'h38: c = 8'h2A;
            8'h39: c = 8'h28;
            8'h30: c = 8'h29;
            8'h2D: c = 8'h5F;
            8'h3D: c = 8'h2B;
            8'h5B: c = 8'h7B;
            8'h5D: c = 8'h7D;
            8'h3B: c = 8'h3A;
            8'h27: c = 8'h22;
            8'h2C: c = 8'h3C;
            8'h2E: c = 8'h3E;
            8'h2F: c = 8'h3F;
            8'h60: c = 8'h7E;
            default:
            begin
                if (b inside {[8'h61:8'h7A]})
                begin
                    c = b - 8'h20;
                end
                else
                begin
                    c = b;
                end
            end
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/sc2a_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sc2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/sc2a_front.sv
// Front part: decode one item into a store, fetch or no-op operation.
module sc2a_front
    import sc2a_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic                    command,
    input  logic [7:0]              scan_byte,
    input  logic                    decode_enable,
    input  logic [NUM_EXT-1:0][7:0] ext_codes,
    output op_t                     op
);

    logic ext_pending_reg, ext_pending_next;
    logic shift_reg, shift_next;
    logic ctrl_reg, ctrl_next;

    logic       brk;
    logic [6:0] mk;
    logic [7:0] base;
    logic [7:0] ch;

    always_comb
    begin
        ext_pending_next = ext_pending_reg;
        shift_next       = shift_reg;
        ctrl_next        = ctrl_reg;
        op.kind          = OP_NONE;
        op.ch            = 8'h00;
        brk              = scan_byte[7];
        mk               = scan_byte[6:0];
        base             = (mk < 7'h50) ? ascii_lookup(mk) : 8'h00;
        ch               = shift_reg ? shift_map(base) : base;
        if (ctrl_reg && (ch == CH_LOW_C || ch == CH_UP_C))
        begin
            ch = CH_CTRL_C;
        end

        if (command == CMD_POP)
        begin
            op.kind = OP_POP;
        end
        else if (!decode_enable)
        begin
            op.kind = OP_NONE;
        end
        else if (ext_pending_reg)
        begin
            ext_pending_next = 1'b0;
            op.kind          = OP_PUT;
            case (scan_byte)
                SC_EXT_UP:    op.ch = ext_codes[EXT_UP];
                SC_EXT_DOWN:  op.ch = ext_codes[EXT_DOWN];
                SC_EXT_LEFT:  op.ch = ext_codes[EXT_LEFT];
                SC_EXT_RIGHT: op.ch = ext_codes[EXT_RIGHT];
                SC_EXT_PGUP:  op.ch = ext_codes[EXT_PGUP];
                SC_EXT_PGDN:  op.ch = ext_codes[EXT_PGDN];
                default:      op.kind = OP_NONE;
            endcase
        end
        else if (scan_byte == SC_PREFIX)
        begin
            ext_pending_next = 1'b1;
        end
        else if (mk == SC_LSHIFT || mk == SC_RSHIFT)
        begin
            shift_next = !brk;
        end
        else if (mk == SC_CTRL)
        begin
            ctrl_next = !brk;
        end
        else if (mk == SC_ALT)
        begin
            op.kind = OP_NONE;
        end
        else if (mk == SC_BKSP)
        begin
            op.kind = brk ? OP_NONE : OP_PUT;
            op.ch   = CH_BKSP;
        end
        else if (mk == SC_ENTER)
        begin
            op.kind = brk ? OP_NONE : OP_PUT;
            op.ch   = CH_ENTER;
        end
        else if (!brk && base != 8'h00)
        begin
            op.kind = OP_PUT;
            op.ch   = ch;
        end
    end

    // Advance the key state only on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_pending_reg <= 1'b0;
            shift_reg       <= 1'b0;
            ctrl_reg        <= 1'b0;
        end
        else if (take)
        begin
            ext_pending_reg <= ext_pending_next;
            shift_reg       <= shift_next;
            ctrl_reg        <= ctrl_next;
        end
    end

endmodule

### hw/rtl/sc2a_op_queue.sv
// Two-entry queue of decoded operations between front and back.
module sc2a_op_queue
    import sc2a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  op_t  wr_op,
    output logic full,
    input  logic rd_en,
    output logic rd_valid,
    output op_t  rd_op
);

    op_t        mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/sc2a_back.sv
// Back part: character store, read stage and result queue.
module sc2a_back
    import sc2a_pkg::*;
#(
    parameter int FIFO_DEPTH = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    input  op_t          op,
    output logic         op_ready,
    output logic         empty,
    input  logic         pop,
    output logic [7:0]   popped_char,
    output logic [7:0]   fifo_level,
    output back_status_t status
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          store_full, store_empty;
    logic          room, issue, do_put, do_get;
    logic [CW+7:0] level_wide;
    logic [7:0]    rdata;

    logic          b_valid_reg;
    logic          b_read_reg;
    logic [7:0]    b_level_reg;

    result_t          oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0] oq_count_reg, oq_count_next;
    logic             oq_push, oq_pop;
    result_t          oq_in;

    assign store_full  = (count_reg == CW'(FIFO_DEPTH));
    assign store_empty = (count_reg == '0);

    // Issue only when the result queue can absorb this word and the one in flight
    assign room     = (4'(oq_count_reg) + 4'(b_valid_reg)) < 4'(OQ_DEPTH);
    assign op_ready = room;
    assign issue    = op_valid && room;
    assign do_put   = issue && (op.kind == OP_PUT) && !store_full;
    assign do_get   = issue && (op.kind == OP_POP) && !store_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_put)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_get)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign level_wide = {8'h00, count_next};

    sc2a_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_put),
        .waddr (wr_ptr_reg),
        .wdata (op.ch),
        .re    (do_get),
        .raddr (rd_ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_put)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_get)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg   <= count_next;
            b_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_read_reg  <= do_get;
            b_level_reg <= level_wide[7:0];
        end
    end

    // Result queue
    assign oq_push   = b_valid_reg;
    assign oq_pop    = pop && !empty;
    assign oq_in.ch  = b_read_reg ? rdata : 8'h00;
    assign oq_in.level = b_level_reg;

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (oq_push && !oq_pop)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (!oq_push && oq_pop)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_mem_reg[oq_wr_reg] <= oq_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_count_reg <= oq_count_next;
        end
    end

    assign empty       = (oq_count_reg == '0);
    assign popped_char = oq_mem_reg[oq_rd_reg].ch;
    assign fifo_level  = oq_mem_reg[oq_rd_reg].level;

    assign status.oq_count    = oq_count_reg;
    assign status.stage_valid = b_valid_reg;
    assign status.store_full  = store_full;
    assign status.store_empty = store_empty;

endmodule

### hw/rtl/scancode_to_ascii_fifo.sv
// Top level: PS/2 set-1 scancode decoder with a character FIFO and APB registers.
//
//  channel   handshake         payload                     direction
//  -------   ---------------   -------------------------   ---------
//  item      push / full       command, scan_byte          in
//  result    empty / pop       popped_char, fifo_level     out
//  config    psel / penable    paddr, pwdata, prdata       in/out
//
// One word is accepted per cycle while full is low, and one result word is produced for each.
// A taken word enters the op queue; when the result queue has room the back
// applies it to the store, and the RAM read data is then written into the
// result queue, from which it reaches the result ports.
// The character store has no reset and no clearing pass; only pointers, count
// and key state are cleared, so the block accepts words straight after reset.
// full rises when the op queue holds two words; the back stalls when the
// four-entry result queue cannot take another word, and the front stalls in turn.
module scancode_to_ascii_fifo
    import sc2a_pkg::*;
#(
    parameter int FIFO_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [7:0]  scan_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  popped_char,
    output logic [7:0]  fifo_level,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                    decode_enable_reg;
    logic [NUM_EXT-1:0][7:0] ext_codes_reg;
    logic                    cfg_write;
    logic [2:0]              cfg_index;

    logic         take;
    op_t          front_op;
    op_t          queue_op;
    logic         op_valid;
    logic         op_ready;
    back_status_t back_status;

    // Configuration registers: written in the APB access phase, never stalled
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_enable_reg        <= 1'b1;
            ext_codes_reg[EXT_UP]    <= 8'd128;
            ext_codes_reg[EXT_DOWN]  <= 8'd129;
            ext_codes_reg[EXT_LEFT]  <= 8'd130;
            ext_codes_reg[EXT_RIGHT] <= 8'd131;
            ext_codes_reg[EXT_PGUP]  <= 8'd132;
            ext_codes_reg[EXT_PGDN]  <= 8'd133;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DECODE_ENABLE: decode_enable_reg        <= pwdata[0];
                REG_ARROW_UP:      ext_codes_reg[EXT_UP]    <= pwdata[7:0];
                REG_ARROW_DOWN:    ext_codes_reg[EXT_DOWN]  <= pwdata[7:0];
                REG_ARROW_LEFT:    ext_codes_reg[EXT_LEFT]  <= pwdata[7:0];
                REG_ARROW_RIGHT:   ext_codes_reg[EXT_RIGHT] <= pwdata[7:0];
                REG_PAGE_UP:       ext_codes_reg[EXT_PGUP]  <= pwdata[7:0];
                REG_PAGE_DOWN:     ext_codes_reg[EXT_PGDN]  <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    // Read back; addresses beyond the list return zero
    always_comb
    begin
        case (cfg_index)
            REG_DECODE_ENABLE: prdata = {31'h0, decode_enable_reg};
            REG_ARROW_UP:      prdata = {24'h0, ext_codes_reg[EXT_UP]};
            REG_ARROW_DOWN:    prdata = {24'h0, ext_codes_reg[EXT_DOWN]};
            REG_ARROW_LEFT:    prdata = {24'h0, ext_codes_reg[EXT_LEFT]};
            REG_ARROW_RIGHT:   prdata = {24'h0, ext_codes_reg[EXT_RIGHT]};
            REG_PAGE_UP:       prdata = {24'h0, ext_codes_reg[EXT_PGUP]};
            REG_PAGE_DOWN:     prdata = {24'h0, ext_codes_reg[EXT_PGDN]};
            default:           prdata = 32'h0;
        endcase
    end

    // Front: take a word whenever the op queue has room
    assign take = push && !full;

    sc2a_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .command       (command),
        .scan_byte     (scan_byte),
        .decode_enable (decode_enable_reg),
        .ext_codes     (ext_codes_reg),
        .op            (front_op)
    );

    // Decouple front and back so each can stall on its own
    sc2a_op_queue u_op_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (take),
        .wr_op    (front_op),
        .full     (full),
        .rd_en    (op_valid && op_ready),
        .rd_valid (op_valid),
        .rd_op    (queue_op)
    );

    // Back: apply the operation to the character store and queue the result
    sc2a_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op          (queue_op),
        .op_ready    (op_ready),
        .empty       (empty),
        .pop         (pop),
        .popped_char (popped_char),
        .fifo_level  (fifo_level),
        .status      (back_status)
    );

`ifndef SYNTHESIS
    // The store cannot be full and empty at once
    a_store_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(back_status.store_full && back_status.store_empty))
        else $error("character store reports full and empty together");

    // Words in the result queue plus the one in flight never exceed its depth
    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        (4'(back_status.oq_count) + 4'(back_status.stage_valid)) <= 4'(OQ_DEPTH))
        else $error("result queue overrun");

    // A word taken into an empty op queue is visible to the back next cycle
    a_op_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !op_valid) |=> op_valid)
        else $error("accepted word lost before the back part");
`endif

endmodule
